@@ src/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Queue sizing, field widths, command and status codes, and the structs
// that pass between the cells of the sorted row.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int ID_BITS       = 16;
  localparam int PRIORITY_BITS = 4;

  // Entry index and fill count widths
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2
  } spq_status_t;

  // Operation broadcast to every cell in a cycle
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic [ID_BITS-1:0]       id;
    logic [PRIORITY_BITS-1:0] prio;
  } spq_op_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic [ID_BITS-1:0]       id;
    logic [PRIORITY_BITS-1:0] prio;
    logic                     keep;
  } spq_link_t;

endpackage

`default_nettype wire

@@ src/spq_in_if.sv @@
// ----------------------------------------------------------------------------
// spq_in_if: command channel of the stable priority queue
// Valid/ready handshake carrying one insert or remove item.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [spq_pkg::ID_BITS-1:0]       patient_id;
  logic [spq_pkg::PRIORITY_BITS-1:0] priority_req;

  modport source (output valid, output cmd, output patient_id, output priority_req,
                  input ready);
  modport sink   (input valid, input cmd, input patient_id, input priority_req,
                  output ready);
endinterface

`default_nettype wire

@@ src/spq_out_if.sv @@
// ----------------------------------------------------------------------------
// spq_out_if: result channel of the stable priority queue
// Valid/ready handshake carrying one result item per command.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_out_if;
  logic                        valid;
  logic                        ready;
  logic [spq_pkg::ID_BITS-1:0] removed_id;
  logic [1:0]                  status;
  logic [spq_pkg::CNT_W-1:0]   occupancy;

  modport source (output valid, output removed_id, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input removed_id, input status, input occupancy,
                  output ready);
endinterface

`default_nettype wire

@@ src/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted row
// Holds one entry. On insert it keeps its entry, takes the new one or takes
// its left neighbor's; on remove it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire                          clk,
  input  wire spq_pkg::spq_op_t        op,
  input  wire [spq_pkg::IDX_W-1:0]     idx,
  input  wire [spq_pkg::CNT_W-1:0]     count,
  input  wire spq_pkg::spq_link_t      left,
  input  wire spq_pkg::spq_link_t      right,
  output spq_pkg::spq_link_t           self
);
  import spq_pkg::*;

  logic [ID_BITS-1:0]       id_r,   id_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;
  logic                     occupied;
  logic                     keep;

  // Stay in place when holding an entry that goes ahead of the new one
  assign occupied = CNT_W'(idx) < count;
  assign keep     = occupied && (prio_r <= op.prio);

  assign self.id   = id_r;
  assign self.prio = prio_r;
  assign self.keep = keep;

  // Pick the next entry
  always_comb begin
    id_nxt   = id_r;
    prio_nxt = prio_r;
    priority if (op.ins) begin
      priority if (keep) begin
        id_nxt   = id_r;
        prio_nxt = prio_r;
      end else if (left.keep) begin
        id_nxt   = op.id;
        prio_nxt = op.prio;
      end else begin
        id_nxt   = left.id;
        prio_nxt = left.prio;
      end
    end else if (op.rem) begin
      id_nxt   = right.id;
      prio_nxt = right.prio;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
  end

endmodule

`default_nettype wire

@@ src/stable_priority_queue.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded priority queue with first-in, first-out ties
// Row of cells kept sorted by priority, head in cell zero.
// ----------------------------------------------------------------------------
// Takes one insert or remove item per clock cycle while results are taken,
// and returns one result item for each, in the cycle after it is accepted,
// from a result register. Every cell compares its own entry with the new
// priority in parallel, so an insert or a remove completes as it is accepted;
// the only limit on the rate is the result register, which frees as soon as
// the result is taken, so a new item enters in the same cycle the previous
// result leaves. Inserts into a full queue return status full and change
// nothing; removes from an empty queue return status underflow and identifier zero.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue (
  input  wire       clk,
  input  wire       rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r;
  logic [ID_BITS-1:0] out_id_r, out_id_nxt;
  spq_status_t        out_status_r, out_status_nxt;
  logic [CNT_W-1:0]   out_occ_r;
  logic               in_ready;
  logic               accept;
  logic               full;
  logic               empty;
  spq_op_t            op;
  spq_link_t          link [QUEUE_DEPTH];
  spq_link_t          head_edge;
  spq_link_t          tail_edge;

  // Accept while the result register is free or being drained
  assign in_ready     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = in_ready;
  assign accept       = in_ch.valid && in_ready;

  assign full  = count_r == CNT_W'(QUEUE_DEPTH);
  assign empty = count_r == '0;

  // Broadcast the operation to the row
  assign op.ins  = accept && (in_ch.cmd == CMD_INSERT) && !full;
  assign op.rem  = accept && (in_ch.cmd == CMD_REMOVE) && !empty;
  assign op.id   = in_ch.patient_id;
  assign op.prio = in_ch.priority_req;

  // Boundaries of the row: nothing ahead of the head, nothing behind the tail
  assign head_edge = '{id: '0, prio: '0, keep: 1'b1};
  assign tail_edge = '{id: '0, prio: '0, keep: 1'b0};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_link_t left_in, right_in;

    if (i == 0) begin : g_head
      assign left_in = head_edge;
    end else begin : g_mid_l
      assign left_in = link[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_in = tail_edge;
    end else begin : g_mid_r
      assign right_in = link[i+1];
    end

    spq_cell u_cell (
      .clk   (clk),
      .op    (op),
      .idx   (IDX_W'(i)),
      .count (count_r),
      .left  (left_in),
      .right (right_in),
      .self  (link[i])
    );
  end

  // Fill count
  always_comb begin
    count_nxt = count_r;
    priority if (op.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (op.rem) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Result fields
  always_comb begin
    out_id_nxt     = '0;
    out_status_nxt = ST_DONE;
    unique case (in_ch.cmd)
      CMD_INSERT: begin
        if (full) out_status_nxt = ST_FULL;
      end
      CMD_REMOVE: begin
        if (empty) out_status_nxt = ST_UNDERFLOW;
        else       out_id_nxt     = link[0].id;
      end
      default: out_status_nxt = ST_DONE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_id_r     <= out_id_nxt;
      out_status_r <= out_status_nxt;
      out_occ_r    <= count_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.removed_id = out_id_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.occupancy  = out_occ_r;

  // Fill count stays within the row
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  // A remove from a non-empty queue drops the count by one
  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    op.rem |=> count_r == $past(count_r) - 1'b1)
    else $error("remove did not shrink the queue");

  // Reported occupancy follows the fill count
  a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_occ_r == count_r)
    else $error("occupancy differs from fill count");

  // Underflow carries no identifier and an empty queue
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_UNDERFLOW |-> out_id_r == '0 && out_occ_r == '0)
    else $error("underflow result with data");

endmodule

`default_nettype wire

@@ tb/stable_priority_queue_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_tb: self-checking bench for the stable priority queue
// Drives insert and remove items through the command channel and checks each
// result item, field by field, against a predictor that keeps its own sorted
// copy of the queue. Both sides idle at random; the random part runs in
// phases with different insert mixes, so the queue fills and drains often.
// ----------------------------------------------------------------------------

module stable_priority_queue_tb;
  import spq_pkg::*;

  typedef struct {
    logic                     cmd;
    logic [ID_BITS-1:0]       id;
    logic [PRIORITY_BITS-1:0] prio;
    bit                       drain_first;  // hold off until all results are in
  } triage_req_t;

  typedef struct {
    logic [ID_BITS-1:0] removed_id;
    spq_status_t        status;
    logic [CNT_W-1:0]   occupancy;
  } triage_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  spq_in_if  in_bus ();
  spq_out_if out_bus ();

  stable_priority_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #1 clk = ~clk;

  // Predictor copy of the queue, head at index zero
  logic [ID_BITS-1:0]       ward_ids [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] ward_prio [QUEUE_DEPTH];
  int                       ward_count = 0;

  triage_req_t pending_requests[$];
  triage_res_t expected_outcomes[$];
  int          mismatches = 0;
  int          cyc = 0;
  logic        calm;

  // Long window with no idling on either side
  assign calm = (cyc >= 1200) && (cyc < 1900);

  // Apply one item to the predictor and return its result
  function automatic triage_res_t triage_step(triage_req_t r);
    triage_res_t res;
    int          pos;
    res.removed_id = '0;
    res.status     = ST_DONE;
    if (r.cmd == CMD_INSERT) begin
      if (ward_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // New entry goes behind every entry of equal or lower number
        pos = 0;
        while (pos < ward_count && ward_prio[pos] <= r.prio) pos++;
        for (int k = ward_count; k > pos; k--) begin
          ward_ids[k]  = ward_ids[k-1];
          ward_prio[k] = ward_prio[k-1];
        end
        ward_ids[pos]  = r.id;
        ward_prio[pos] = r.prio;
        ward_count++;
      end
    end else begin
      if (ward_count == 0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        res.removed_id = ward_ids[0];
        for (int k = 1; k < ward_count; k++) begin
          ward_ids[k-1]  = ward_ids[k];
          ward_prio[k-1] = ward_prio[k];
        end
        ward_count--;
      end
    end
    res.occupancy = ward_count[CNT_W-1:0];
    return res;
  endfunction

  task automatic note_mismatch(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
  endtask

  task automatic queue_request(logic cmd, logic [ID_BITS-1:0] id,
                               logic [PRIORITY_BITS-1:0] prio, bit drain_first);
    triage_req_t r;
    r.cmd         = cmd;
    r.id          = id;
    r.prio        = prio;
    r.drain_first = drain_first;
    pending_requests.push_back(r);
  endtask

  // Known values on every input from time zero
  initial begin
    in_bus.valid        = 1'b0;
    in_bus.cmd          = CMD_INSERT;
    in_bus.patient_id   = '0;
    in_bus.priority_req = '0;
    out_bus.ready       = 1'b0;
  end

  // Driver: present pending items, predict each one as it is accepted
  always @(posedge clk) begin
    triage_req_t r;
    logic        drained;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        r.cmd  = in_bus.cmd;
        r.id   = in_bus.patient_id;
        r.prio = in_bus.priority_req;
        expected_outcomes.push_back(triage_step(r));
      end
      // Hold the item until it is taken
      if (!(in_bus.valid && !in_bus.ready)) begin
        drained = (expected_outcomes.size() == 0) && !out_bus.valid && !in_bus.valid;
        if (pending_requests.size() > 0 &&
            (!pending_requests[0].drain_first || drained) &&
            (calm || $urandom_range(0, 99) >= 16)) begin
          r = pending_requests.pop_front();
          in_bus.valid        <= 1'b1;
          in_bus.cmd          <= r.cmd;
          in_bus.patient_id   <= r.id;
          in_bus.priority_req <= r.prio;
        end else begin
          // Idle: toggle the payload as noise
          in_bus.valid        <= 1'b0;
          in_bus.cmd          <= 1'($urandom);
          in_bus.patient_id   <= ID_BITS'($urandom);
          in_bus.priority_req <= PRIORITY_BITS'($urandom);
        end
      end
    end
  end

  // Monitor: check each result against the oldest expectation
  always @(posedge clk) begin
    triage_res_t want;
    cyc <= cyc + 1;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_outcomes.size() == 0) begin
          note_mismatch("unexpected result, removed_id", 0, out_bus.removed_id);
        end else begin
          want = expected_outcomes.pop_front();
          if (out_bus.removed_id !== want.removed_id)
            note_mismatch("removed_id", want.removed_id, out_bus.removed_id);
          if (out_bus.status !== want.status)
            note_mismatch("status", want.status, out_bus.status);
          if (out_bus.occupancy !== want.occupancy)
            note_mismatch("occupancy", want.occupancy, out_bus.occupancy);
        end
      end
      out_bus.ready <= calm || ($urandom_range(0, 99) >= 16);
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int insert_pct;
    int phase_len;
    int prio_hi;
    bit drain_phase;

    // Underflow, extremes of the fields and a tie at the lowest number
    queue_request(CMD_REMOVE, 16'hFFFF, 4'hF, 1'b0);
    queue_request(CMD_INSERT, 16'h0000, 4'h0, 1'b0);
    queue_request(CMD_INSERT, 16'hFFFF, 4'hF, 1'b0);
    queue_request(CMD_INSERT, 16'h1234, 4'h0, 1'b0);
    queue_request(CMD_REMOVE, 16'h0000, 4'h0, 1'b0);
    queue_request(CMD_REMOVE, 16'hAAAA, 4'h5, 1'b0);
    queue_request(CMD_REMOVE, 16'h5555, 4'hA, 1'b0);
    // Fill to the brim with ties at the top number, then overflow once
    for (int i = 0; i < QUEUE_DEPTH; i++)
      queue_request(CMD_INSERT, ID_BITS'($urandom), (i % 3 == 0) ? 4'hF : 4'(i % 5),
                    i == 0);
    queue_request(CMD_INSERT, 16'hBEEF, 4'h0, 1'b0);
    queue_request(CMD_REMOVE, 16'h0000, 4'h0, 1'b0);

    // Random phases with different insert mixes and priority spreads
    while (pending_requests.size() < 1550) begin
      phase_len = $urandom_range(40, 160);
      case ($urandom_range(0, 3))
        0:       insert_pct = 25;
        1:       insert_pct = 50;
        2:       insert_pct = 75;
        default: insert_pct = 90;
      endcase
      prio_hi     = ($urandom_range(0, 2) == 0) ? 1 : 15;
      drain_phase = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len; i++)
        queue_request(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
                      ID_BITS'($urandom), PRIORITY_BITS'($urandom_range(0, prio_hi)),
                      drain_phase && (i == 0));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last item and its result, then let the pipe settle
    @(negedge clk);
    while (pending_requests.size() > 0 || in_bus.valid || expected_outcomes.size() > 0)
      @(negedge clk);
    repeat (8) @(negedge clk);

    if (mismatches == 0) begin
      $display("stable_priority_queue_tb: done, clean");
    end else begin
      $display("stable_priority_queue_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("stable_priority_queue_tb: done, errors");
    $finish;
  end

endmodule
